// ===== hw/rtl/wtdp_pkg.sv =====
// Shared types and constants for the weighted triple dot product block.
package wtdp_pkg;

    // Default element and accumulator widths
    localparam int ELEM_WIDTH_DEF = 16;
    localparam int ACC_WIDTH_DEF  = 64;

    // Width of each sum on the result channel
    localparam int OUT_WIDTH = 64;

    // Configuration register word indexes
    localparam logic REG_USE_WEIGHTS = 1'b0;

    // Step commands from the sequencer to the datapath
    typedef struct packed {
        logic load;     // capture the input word
        logic pair;     // pair products a*b, a*c, b*b
        logic mul_lo;   // low half of pair product times weight
        logic mul_hi;   // high half of pair product times weight
        logic term;     // combine halves and clamp the term
        logic acc;      // saturating accumulate, emit on last
    } wtdp_cmd_t;

    // Status from the datapath to the sequencer
    typedef struct packed {
        logic last;     // captured word closes the vector
        logic out_busy; // result register full and not taken this cycle
    } wtdp_stat_t;

endpackage

// ===== hw/rtl/wtdp_ctrl.sv =====
// Sequencer that steps one input word through the datapath.
module wtdp_ctrl (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  s_axis_tvalid,
    output logic                  s_axis_tready,
    input  wtdp_pkg::wtdp_stat_t  stat,
    output wtdp_pkg::wtdp_cmd_t   cmd
);
    import wtdp_pkg::*;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_PAIR,
        ST_LO,
        ST_HI,
        ST_TERM,
        ST_ACC
    } state_t;

    state_t state_reg;
    state_t state_next;

    // Next state and step commands
    always_comb begin
        state_next = state_reg;
        cmd        = '0;
        unique case (state_reg)
            ST_IDLE: begin
                cmd.load = s_axis_tvalid;
                if (s_axis_tvalid) begin
                    state_next = ST_PAIR;
                end
            end
            ST_PAIR: begin
                cmd.pair   = 1'b1;
                state_next = ST_LO;
            end
            ST_LO: begin
                cmd.mul_lo = 1'b1;
                state_next = ST_HI;
            end
            ST_HI: begin
                cmd.mul_hi = 1'b1;
                state_next = ST_TERM;
            end
            ST_TERM: begin
                cmd.term   = 1'b1;
                state_next = ST_ACC;
            end
            ST_ACC: begin
                // hold the closing word until the result register is free
                cmd.acc = !(stat.last && stat.out_busy);
                if (cmd.acc) begin
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    assign s_axis_tready = (state_reg == ST_IDLE);

    // State register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    // An accepted word always starts the product step
    a_accept_to_pair: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_axis_tvalid && s_axis_tready) |=> (state_reg == ST_PAIR))
        else $error("accepted word did not start the product step");

    // Product, multiply and clamp steps run without gaps
    a_fixed_steps: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_PAIR) |=> (state_reg == ST_LO) ##1 (state_reg == ST_HI)
            ##1 (state_reg == ST_TERM) ##1 (state_reg == ST_ACC))
        else $error("datapath steps out of order");

    // A closing word waits while the result register is held
    a_hold_on_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_ACC && stat.last && stat.out_busy) |=> (state_reg == ST_ACC))
        else $error("closing word left accumulate step while output busy");

endmodule

// ===== hw/rtl/wtdp_datapath.sv =====
// Three-lane multiply, clamp and saturating accumulate datapath with result register.
module wtdp_datapath #(
    parameter int ELEM_WIDTH = wtdp_pkg::ELEM_WIDTH_DEF,
    parameter int ACC_WIDTH  = wtdp_pkg::ACC_WIDTH_DEF
) (
    input  logic                                 aclk,
    input  logic                                 aresetn,
    input  logic signed [ELEM_WIDTH-1:0]         elem_a,
    input  logic signed [ELEM_WIDTH-1:0]         elem_b,
    input  logic signed [ELEM_WIDTH-1:0]         elem_c,
    input  logic signed [ELEM_WIDTH-1:0]         elem_w,
    input  logic                                 is_last,
    input  logic                                 use_weights,
    input  wtdp_pkg::wtdp_cmd_t                  cmd,
    output wtdp_pkg::wtdp_stat_t                 stat,
    input  logic                                 m_ready,
    output logic                                 m_valid,
    output logic signed [wtdp_pkg::OUT_WIDTH-1:0] sum_ab,
    output logic signed [wtdp_pkg::OUT_WIDTH-1:0] sum_ac,
    output logic signed [wtdp_pkg::OUT_WIDTH-1:0] sum_bb,
    output logic                                 saturated
);
    import wtdp_pkg::*;

    localparam int EW    = ELEM_WIDTH;
    localparam int AW    = ACC_WIDTH;
    localparam int PW    = 3 * EW + 2;           // full weighted product
    localparam int XW    = (PW > AW) ? PW : AW;  // width for range check
    localparam int LANES = 3;
    localparam int L_AB  = 0;
    localparam int L_AC  = 1;
    localparam int L_BB  = 2;

    localparam logic signed [AW-1:0] ACC_MAX = {1'b0, {(AW-1){1'b1}}};
    localparam logic signed [AW-1:0] ACC_MIN = {1'b1, {(AW-1){1'b0}}};

    // Captured input word
    logic signed [EW-1:0]     a_reg, b_reg, c_reg, w_reg;
    logic                     last_reg;

    // Per-lane pipeline registers
    logic signed [EW:0]       weff_reg;
    logic signed [2*EW-1:0]   pair_reg [LANES];
    logic signed [2*EW+1:0]   lo_reg   [LANES];
    logic signed [2*EW+1:0]   hi_reg   [LANES];
    logic signed [AW-1:0]     term_reg [LANES];
    logic signed [AW-1:0]     acc_reg  [LANES];
    logic                     ovf_reg;

    // Result register
    logic                     m_valid_reg;
    logic signed [AW-1:0]     res_reg  [LANES];
    logic                     sat_reg;

    // Combinational lane values
    logic signed [EW:0]       weff_next;
    logic signed [2*EW-1:0]   pair_next [LANES];
    logic signed [EW:0]       mul_opnd  [LANES];
    logic signed [2*EW+1:0]   mul_prod  [LANES];
    logic signed [PW-1:0]     full      [LANES];
    logic signed [XW-1:0]     full_x    [LANES];
    logic        [XW-AW:0]    full_top  [LANES];
    logic signed [AW-1:0]     term_next [LANES];
    logic        [LANES-1:0]  term_ovf;
    logic signed [AW:0]       sum       [LANES];
    logic signed [AW-1:0]     acc_sat   [LANES];
    logic        [LANES-1:0]  add_ovf;

    // Effective weight: the element itself, or unit weight as 2^(EW-1)
    assign weff_next = use_weights ? {w_reg[EW-1], w_reg} : {2'b01, {(EW-1){1'b0}}};

    // Pair products
    assign pair_next[L_AB] = a_reg * b_reg;
    assign pair_next[L_AC] = a_reg * c_reg;
    assign pair_next[L_BB] = b_reg * b_reg;

    always_comb begin
        for (int i = 0; i < LANES; i++) begin
            // One weight multiplier per lane, used for the low then the high half
            if (cmd.mul_hi) begin
                mul_opnd[i] = {pair_reg[i][2*EW-1], pair_reg[i][2*EW-1:EW]};
            end else begin
                mul_opnd[i] = {1'b0, pair_reg[i][EW-1:0]};
            end
            mul_prod[i] = mul_opnd[i] * weff_reg;

            // Recombine halves, clamp to the accumulator range
            full[i]     = {hi_reg[i], {EW{1'b0}}} + PW'(lo_reg[i]);
            full_x[i]   = XW'(full[i]);
            full_top[i] = full_x[i][XW-1:AW-1];
            term_ovf[i] = !((&full_top[i]) || !(|full_top[i]));
            if (term_ovf[i]) begin
                term_next[i] = full_x[i][XW-1] ? ACC_MIN : ACC_MAX;
            end else begin
                term_next[i] = full_x[i][AW-1:0];
            end

            // Saturating accumulate
            sum[i]     = (AW+1)'(acc_reg[i]) + (AW+1)'(term_reg[i]);
            add_ovf[i] = sum[i][AW] ^ sum[i][AW-1];
            if (add_ovf[i]) begin
                acc_sat[i] = sum[i][AW] ? ACC_MIN : ACC_MAX;
            end else begin
                acc_sat[i] = sum[i][AW-1:0];
            end
        end
    end

    // Payload registers
    always_ff @(posedge aclk) begin
        if (cmd.load) begin
            a_reg    <= elem_a;
            b_reg    <= elem_b;
            c_reg    <= elem_c;
            w_reg    <= elem_w;
            last_reg <= is_last;
        end
        if (cmd.pair) begin
            weff_reg <= weff_next;
        end
        for (int i = 0; i < LANES; i++) begin
            if (cmd.pair) begin
                pair_reg[i] <= pair_next[i];
            end
            if (cmd.mul_lo) begin
                lo_reg[i] <= mul_prod[i];
            end
            if (cmd.mul_hi) begin
                hi_reg[i] <= mul_prod[i];
            end
            if (cmd.term) begin
                term_reg[i] <= term_next[i];
            end
            if (cmd.acc && last_reg) begin
                res_reg[i] <= acc_sat[i];
            end
        end
        if (cmd.acc && last_reg) begin
            sat_reg <= ovf_reg || (|add_ovf);
        end
    end

    // Accumulators, sticky flag and result valid
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < LANES; i++) begin
                acc_reg[i] <= '0;
            end
            ovf_reg     <= 1'b0;
            m_valid_reg <= 1'b0;
        end else begin
            if (m_valid_reg && m_ready) begin
                m_valid_reg <= 1'b0;
            end
            if (cmd.term) begin
                ovf_reg <= ovf_reg || (|term_ovf);
            end
            if (cmd.acc) begin
                if (last_reg) begin
                    for (int i = 0; i < LANES; i++) begin
                        acc_reg[i] <= '0;
                    end
                    ovf_reg     <= 1'b0;
                    m_valid_reg <= 1'b1;
                end else begin
                    for (int i = 0; i < LANES; i++) begin
                        acc_reg[i] <= acc_sat[i];
                    end
                    ovf_reg <= ovf_reg || (|add_ovf);
                end
            end
        end
    end

    assign stat.last     = last_reg;
    assign stat.out_busy = m_valid_reg && !m_ready;

    assign m_valid   = m_valid_reg;
    assign sum_ab    = OUT_WIDTH'(res_reg[L_AB]);
    assign sum_ac    = OUT_WIDTH'(res_reg[L_AC]);
    assign sum_bb    = OUT_WIDTH'(res_reg[L_BB]);
    assign saturated = sat_reg;

    // Closing a vector leaves cleared accumulators and flag
    a_clear_after_last: assert property (@(posedge aclk) disable iff (!aresetn)
        (cmd.acc && last_reg) |=> (acc_reg[L_AB] == '0 && acc_reg[L_AC] == '0
            && acc_reg[L_BB] == '0 && !ovf_reg))
        else $error("state not cleared after closing word");

    // A result is never loaded over one that is still held
    a_no_overwrite: assert property (@(posedge aclk) disable iff (!aresetn)
        (cmd.acc && last_reg) |-> !(m_valid_reg && !m_ready))
        else $error("result register overwritten while held");

    // A result only appears after a closing accumulate
    a_valid_source: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_valid_reg) |-> $past(cmd.acc && last_reg))
        else $error("result valid without closing word");

endmodule

// ===== hw/rtl/weighted_triple_dot_product.sv =====
// Top level: stream ports, configuration register and sequencer/datapath hookup.
//
// Streaming weighted triple dot product. Each word on the s_axis channel
// carries one element of vectors a, b, c and weight w (signed Q1.15 at the
// default width); s_axis_tlast marks the final element. The block keeps
// three saturating accumulators for a.b, a.c and b.b, each product scaled
// by w when use_weights is set (register 0, byte address 0), else by unit
// weight. On the word with tlast the three Q19.45 sums go out on m_axis
// with the sticky saturation flag in m_axis_tuser, and the sums clear.
// Each word takes an accept step, then pair products, low- and high-half
// weight multiplies on one shared multiplier per lane, term clamp and
// accumulate; the next word is taken only after that accumulate step. The
// closing word's accumulate step loads the result register, which lets the
// next vector proceed while a result waits; a closing word stalls in its
// accumulate step only while the previous result waits on a stalled receiver.
// Reset (aresetn low, synchronous) clears the sums, the flag, the output
// valid and use_weights. Write use_weights only while the block is idle.
module weighted_triple_dot_product #(
    parameter int ELEM_WIDTH = wtdp_pkg::ELEM_WIDTH_DEF,
    parameter int ACC_WIDTH  = wtdp_pkg::ACC_WIDTH_DEF,
    parameter int S_TDATA_W  = ((4 * ELEM_WIDTH + 7) / 8) * 8
) (
    input  logic                   aclk,
    input  logic                   aresetn,
    // APB configuration port
    input  logic                   psel,
    input  logic                   penable,
    input  logic                   pwrite,
    input  logic [2:0]             paddr,
    input  logic [31:0]            pwdata,
    output logic [31:0]            prdata,
    output logic                   pready,
    // Input stream
    input  logic                   s_axis_tvalid,
    output logic                   s_axis_tready,
    input  logic [S_TDATA_W-1:0]   s_axis_tdata,  // elem_a, elem_b, elem_c, elem_w, zero pad
    input  logic                   s_axis_tlast,  // is_last
    // Result stream
    output logic                   m_axis_tvalid,
    input  logic                   m_axis_tready,
    output logic [3*wtdp_pkg::OUT_WIDTH-1:0] m_axis_tdata, // sum_ab, sum_ac, sum_bb
    output logic                   m_axis_tuser   // saturated
);
    import wtdp_pkg::*;

    localparam int EW = ELEM_WIDTH;

    logic                          use_weights_reg;
    wtdp_cmd_t                     cmd;
    wtdp_stat_t                    stat;
    logic signed [OUT_WIDTH-1:0]   sum_ab, sum_ac, sum_bb;
    logic                          cfg_write;

    // Configuration register
    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            use_weights_reg <= 1'b0;
        end else if (cfg_write && paddr[2] == REG_USE_WEIGHTS) begin
            use_weights_reg <= pwdata[0];
        end
    end

    assign prdata = (paddr[2] == REG_USE_WEIGHTS) ? {31'b0, use_weights_reg} : 32'b0;

    wtdp_ctrl u_ctrl (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .stat          (stat),
        .cmd           (cmd)
    );

    wtdp_datapath #(
        .ELEM_WIDTH (ELEM_WIDTH),
        .ACC_WIDTH  (ACC_WIDTH)
    ) u_datapath (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .elem_a      (s_axis_tdata[EW-1:0]),
        .elem_b      (s_axis_tdata[2*EW-1:EW]),
        .elem_c      (s_axis_tdata[3*EW-1:2*EW]),
        .elem_w      (s_axis_tdata[4*EW-1:3*EW]),
        .is_last     (s_axis_tlast),
        .use_weights (use_weights_reg),
        .cmd         (cmd),
        .stat        (stat),
        .m_ready     (m_axis_tready),
        .m_valid     (m_axis_tvalid),
        .sum_ab      (sum_ab),
        .sum_ac      (sum_ac),
        .sum_bb      (sum_bb),
        .saturated   (m_axis_tuser)
    );

    assign m_axis_tdata = {sum_bb, sum_ac, sum_ab};

endmodule

// ===== verif/weighted_triple_dot_product_tb.sv =====
// Self-checking testbench for the weighted triple dot product stream block.
module weighted_triple_dot_product_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import wtdp_pkg::*;

    localparam int     EW              = ELEM_WIDTH_DEF;
    localparam longint ACC_MAX         = 64'sh7FFF_FFFF_FFFF_FFFF;
    localparam longint ACC_MIN         = 64'sh8000_0000_0000_0000;
    localparam int     REG_SPARE       = 1;      // register index with nothing behind it
    localparam int     SETTLE_CYCLES   = 16;     // pipeline is 6 deep, give it margin
    localparam int     WATCHDOG_LIMIT  = 4000;
    localparam int     HOLD_CYCLES     = 600;
    localparam int     HOLD_AT_RESULT  = 40;
    localparam int     LONG_VECTOR_LEN = 64;     // back-to-back full-scale terms
    localparam int     RANDOM_PHASES   = 8;
    localparam int     PHASE_WORDS     = 250;

    // One closed vector: three sums and the sticky clamp flag
    typedef struct {
        logic signed [63:0] ab;
        logic signed [63:0] ac;
        logic signed [63:0] bb;
        logic               sat;
    } sums_t;

    // Tracks the three running sums and checks each result word against them
    class triple_dot_tracker;
        bit     weighted;
        longint acc_ab, acc_ac, acc_bb;
        bit     sat_seen;
        sums_t  pending_sums[$];
        int     errors;
        int     words_seen;
        int     sums_checked;

        function new();
            weighted     = 1'b0;
            acc_ab       = 0;
            acc_ac       = 0;
            acc_bb       = 0;
            sat_seen     = 1'b0;
            errors       = 0;
            words_seen   = 0;
            sums_checked = 0;
        endfunction

        function void set_register(int idx, logic [31:0] value);
            if (idx == int'(REG_USE_WEIGHTS))
                weighted = value[0];
        endfunction

        // Q1.15 pair product scaled by w, or by unit weight (shift up to Q3.45)
        function longint scaled_term(logic signed [15:0] x, logic signed [15:0] y,
                                     logic signed [15:0] w);
            longint p;
            p = longint'(x) * longint'(y);
            if (weighted)
                return p * longint'(w);
            return p * (longint'(1) <<< (EW - 1));
        endfunction

        function longint sat_add(longint acc, longint t);
            longint r;
            r = acc + t;
            if (acc >= 0 && t > 0 && r < 0) begin
                sat_seen = 1'b1;
                return ACC_MAX;
            end
            if (acc < 0 && t < 0 && r >= 0) begin
                sat_seen = 1'b1;
                return ACC_MIN;
            end
            return r;
        endfunction

        // Fold one accepted word into the sums; a closing word queues a result
        function void note_word(logic signed [15:0] a, logic signed [15:0] b,
                                logic signed [15:0] c, logic signed [15:0] w, logic last);
            sums_t s;
            acc_ab = sat_add(acc_ab, scaled_term(a, b, w));
            acc_ac = sat_add(acc_ac, scaled_term(a, c, w));
            acc_bb = sat_add(acc_bb, scaled_term(b, b, w));
            words_seen++;
            if (last) begin
                s.ab  = acc_ab;
                s.ac  = acc_ac;
                s.bb  = acc_bb;
                s.sat = sat_seen;
                pending_sums.push_back(s);
                acc_ab   = 0;
                acc_ac   = 0;
                acc_bb   = 0;
                sat_seen = 1'b0;
            end
        endfunction

        function void check_result(logic [3*OUT_WIDTH-1:0] data, logic user);
            sums_t              want;
            logic signed [63:0] got_ab, got_ac, got_bb;
            got_ab = data[OUT_WIDTH-1:0];
            got_ac = data[2*OUT_WIDTH-1:OUT_WIDTH];
            got_bb = data[3*OUT_WIDTH-1:2*OUT_WIDTH];
            if (pending_sums.size() == 0) begin
                $error("result word with no vector closed: sum_ab %0d sum_ac %0d sum_bb %0d",
                       got_ab, got_ac, got_bb);
                errors++;
                return;
            end
            want = pending_sums.pop_front();
            sums_checked++;
            if (got_ab !== want.ab) begin
                $error("sum_ab: expected %0d, got %0d", want.ab, got_ab);
                errors++;
            end
            if (got_ac !== want.ac) begin
                $error("sum_ac: expected %0d, got %0d", want.ac, got_ac);
                errors++;
            end
            if (got_bb !== want.bb) begin
                $error("sum_bb: expected %0d, got %0d", want.bb, got_bb);
                errors++;
            end
            if (user !== want.sat) begin
                $error("saturated: expected %0d, got %0d", want.sat, user);
                errors++;
            end
        endfunction
    endclass

    logic                        aclk;
    logic                        aresetn;
    logic                        psel;
    logic                        penable;
    logic                        pwrite;
    logic [2:0]                  paddr;
    logic [31:0]                 pwdata;
    logic [31:0]                 prdata;
    logic                        pready;
    logic                        s_axis_tvalid;
    logic                        s_axis_tready;
    logic [63:0]                 s_axis_tdata;   // elem_a, elem_b, elem_c, elem_w
    logic                        s_axis_tlast;   // is_last
    logic                        m_axis_tvalid;
    logic                        m_axis_tready;
    logic [3*OUT_WIDTH-1:0]      m_axis_tdata;   // sum_ab, sum_ac, sum_bb
    logic                        m_axis_tuser;   // saturated

    triple_dot_tracker tracker = new();

    bit send_burst;      // sender skips its gaps
    bit drain_burst;     // receiver skips its stalls
    int reg_writes;
    int idle_cycles;

    weighted_triple_dot_product dut (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .prdata        (prdata),
        .pready        (pready),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tlast  (s_axis_tlast),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

    // Clock
    initial begin
        aclk = 1'b0;
        forever #1 aclk = ~aclk;
    end

    // Watchdog: stop if neither stream moves for too long
    initial begin
        idle_cycles = 0;
        forever begin
            @(posedge aclk);
            if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
                idle_cycles = 0;
            else
                idle_cycles++;
            if (idle_cycles >= WATCHDOG_LIMIT) begin
                $display("Timeout: no word moved for %0d cycles", WATCHDOG_LIMIT);
                $display("Testbench completed WITH ERRORS");
                $finish;
            end
        end
    end

    // Result side: random stalls, one long hold-off to back the block up
    initial begin
        int  gap;
        bit  held;
        held          = 1'b0;
        drain_burst   = 1'b0;
        m_axis_tready = 1'b0;
        wait (aresetn === 1'b1);
        forever begin
            if (!held && tracker.sums_checked == HOLD_AT_RESULT) begin
                held = 1'b1;
                repeat (HOLD_CYCLES) begin
                    @(negedge aclk);
                    m_axis_tready = 1'b0;
                end
            end
            gap = drain_burst ? 0 : $urandom_range(0, 7);
            repeat (gap) begin
                @(negedge aclk);
                m_axis_tready = 1'b0;
            end
            @(negedge aclk);
            m_axis_tready = 1'b1;
            do @(posedge aclk); while (!m_axis_tvalid);
            tracker.check_result(m_axis_tdata, m_axis_tuser);
            if (tracker.sums_checked % 50 == 0)
                drain_burst = ($urandom_range(0, 2) == 0);
        end
    end

    function automatic int rand_elem();
        case ($urandom_range(0, 9))
            0:       return -32768;
            1:       return 32767;
            2:       return 0;
            3:       return -1;
            default: return int'($urandom_range(0, 65535)) - 32768;
        endcase
    endfunction

    // Offer one word and wait for it to be taken
    task automatic send_word(input int a, input int b, input int c, input int w,
                             input logic last);
        int                 gap;
        logic signed [15:0] a16, b16, c16, w16;
        a16 = 16'(a);
        b16 = 16'(b);
        c16 = 16'(c);
        w16 = 16'(w);
        gap = send_burst ? 0 : $urandom_range(0, 7);
        repeat (gap) begin
            @(negedge aclk);
            s_axis_tvalid = 1'b0;
        end
        @(negedge aclk);
        s_axis_tvalid = 1'b1;
        s_axis_tdata  = {w16, c16, b16, a16};
        s_axis_tlast  = last;
        do @(posedge aclk); while (!s_axis_tready);
        tracker.note_word(a16, b16, c16, w16, last);
    endtask

    // Stop sending, let every result drain and the pipeline empty
    task automatic wait_idle();
        @(negedge aclk);
        s_axis_tvalid = 1'b0;
        while (tracker.pending_sums.size() != 0)
            @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    task automatic apb_write(input int idx, input logic [31:0] value);
        @(negedge aclk);
        psel    = 1'b1;
        penable = 1'b0;
        pwrite  = 1'b1;
        paddr   = 3'(idx * 4);
        pwdata  = value;
        @(negedge aclk);
        penable = 1'b1;
        do @(posedge aclk); while (!pready);
        tracker.set_register(idx, value);
        reg_writes++;
        @(negedge aclk);
        psel    = 1'b0;
        penable = 1'b0;
        pwrite  = 1'b0;
    endtask

    task automatic apb_check_weights();
        @(negedge aclk);
        psel    = 1'b1;
        penable = 1'b0;
        pwrite  = 1'b0;
        paddr   = 3'(int'(REG_USE_WEIGHTS) * 4);
        @(negedge aclk);
        penable = 1'b1;
        do @(posedge aclk); while (!pready);
        if (prdata[0] !== tracker.weighted) begin
            $error("use_weights: expected %0d, got %0d", tracker.weighted, prdata[0]);
            tracker.errors++;
        end
        @(negedge aclk);
        psel    = 1'b0;
        penable = 1'b0;
    endtask

    // Main sequence
    initial begin
        int vec_len;
        int sent;
        bit mode;
        aresetn       = 1'b0;
        psel          = 1'b0;
        penable       = 1'b0;
        pwrite        = 1'b0;
        paddr         = '0;
        pwdata        = '0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = '0;
        s_axis_tlast  = 1'b0;
        send_burst    = 1'b0;
        reg_writes    = 0;
        repeat (12) @(negedge aclk);
        aresetn = 1'b1;

        // Unit weight after reset: extremes, single-word and two-word vectors
        apb_check_weights();
        send_word(-32768, -32768, -32768, 0, 1'b1);
        send_word(32767, -32768, 32767, 32767, 1'b0);
        send_word(0, -1, 1, -32768, 1'b1);

        // Weighted: weight at both extremes, zero and minus one
        wait_idle();
        apb_write(int'(REG_USE_WEIGHTS), 32'd1);
        apb_check_weights();
        send_word(-32768, -32768, -32768, -32768, 1'b0);
        send_word(32767, 32767, -32768, 32767, 1'b0);
        send_word(-32768, 32767, -1, 0, 1'b0);
        send_word(12345, -23456, -32768, -1, 1'b1);

        // Mode switch in the middle of a vector keeps the partial sums
        send_word(-32768, 32767, 32767, -32768, 1'b0);
        send_word(20000, -20000, 30000, 16384, 1'b0);
        wait_idle();
        apb_write(int'(REG_USE_WEIGHTS), 32'd0);
        send_word(-7, 32767, -32768, 32767, 1'b1);

        // Write to an unmapped index must not touch use_weights
        wait_idle();
        apb_write(REG_SPARE, 32'd1);
        apb_check_weights();
        send_word(1, -32768, 32767, -32768, 1'b1);

        // One long back-to-back vector of full-scale terms: large sums of both signs
        send_burst = 1'b1;
        for (int i = 0; i < LONG_VECTOR_LEN; i++)
            send_word(-32768, -32768, 32767, 32767, i == LONG_VECTOR_LEN - 1);
        send_burst = 1'b0;

        // Random vectors, mode written anew between phases
        for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
            wait_idle();
            if (phase < 2)
                mode = (phase == 0);
            else
                mode = $urandom_range(0, 1);
            apb_write(int'(REG_USE_WEIGHTS), {31'd0, mode});
            send_burst = ($urandom_range(0, 3) == 0);
            sent = 0;
            while (sent < PHASE_WORDS) begin
                if ($urandom_range(0, 9) == 0)
                    vec_len = $urandom_range(17, 40);
                else
                    vec_len = $urandom_range(1, 8);
                for (int i = 0; i < vec_len; i++)
                    send_word(rand_elem(), rand_elem(), rand_elem(), rand_elem(),
                              i == vec_len - 1);
                sent += vec_len;
            end
        end
        send_burst = 1'b0;

        wait_idle();
        $display("Sent %0d words and checked %0d result words across %0d register writes,",
                 tracker.words_seen, tracker.sums_checked, reg_writes);
        $display("covering both weight modes, a mid-vector mode switch, full-scale terms "
                 , "and stalls.");
        if (tracker.errors == 0 && tracker.pending_sums.size() == 0) begin
            $display("Testbench completed without errors");
        end else begin
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end

endmodule

// ===== sim.f =====
hw/rtl/wtdp_pkg.sv
hw/rtl/wtdp_ctrl.sv
hw/rtl/wtdp_datapath.sv
hw/rtl/weighted_triple_dot_product.sv
verif/weighted_triple_dot_product_tb.sv
